// ===== rtl/anbs_pkg.sv =====
// Shared types and constants for the Annex B NAL boundary scanner.
package anbs_pkg;

    typedef enum logic [1:0] {
        PH_EXPECT  = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_DROP    = 2'd2
    } phase_t;

    localparam logic [4:0] KIND_MASK   = 5'h1F;
    localparam logic [3:0] KIND_EOS    = 4'd11;
    localparam logic [3:0] KIND_MAX    = 4'd12;
    localparam logic [3:0] KIND_NONE   = 4'd0;

    localparam logic [1:0] STATUS_OK     = 2'd0;
    localparam logic [1:0] STATUS_NO_SC  = 2'd1;
    localparam logic [1:0] STATUS_EOS    = 2'd2;

    localparam logic [2:0] PREFIX_NONE = 3'd0;
    localparam logic [2:0] PREFIX_3    = 3'd3;
    localparam logic [2:0] PREFIX_4    = 3'd4;

    localparam logic [1:0] ZRUN_MAX    = 2'd3;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic [31:0] nal_offset;
        logic [31:0] payload_len;
        logic [2:0]  prefix_bytes;
        logic [3:0]  nal_kind;
        logic [1:0]  status;
        logic        final_record;
    } rec_t;

endpackage

// ===== rtl/annexb_nal_boundary_scanner.sv =====
// Annex B start code scanner: one byte per beat in, one NAL unit record per beat out.
// Results go through the input register and the result queue. Throughput: one byte
// per cycle; the input register hands a byte to the scan logic whenever the 4-entry
// result queue has room for two records. A byte that both closes a NAL unit and ends
// the buffer yields two records, drained one per cycle while the master is ready.
// Reset clears the scan state and the queue; the block is ready at once.
module annexb_nal_boundary_scanner
    import anbs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] byte_value
    input  logic        s_axis_tlast,   // end_of_buffer
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // [31:0] nal_offset, [63:32] payload length,
                                        // [66:64] prefix_bytes, [71:67] zero
    output logic [5:0]  m_axis_tuser,   // [3:0] nal_kind, [5:4] status
    output logic        m_axis_tlast    // final_record
);

    // input register
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;

    // scan state
    phase_t      phase_reg, phase_next;
    logic [1:0]  zrun_reg, zrun_next;
    logic [31:0] pos_reg, pos_next;
    logic [31:0] pstart_reg, pstart_next;
    logic [2:0]  cprefix_reg, cprefix_next;
    logic [3:0]  ckind_reg, ckind_next;
    logic        kseen_reg, kseen_next;

    // result queue
    rec_t               fifo_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_CW-1:0] count_reg;

    logic proceed;
    logic room;
    logic pop;
    rec_t rec0, rec1;
    logic rec0_valid, rec1_valid;

    logic       is_zero, is_one, sc_hit;
    logic [4:0] kfield;
    logic [3:0] kind_byte;
    logic       first_byte;
    logic [3:0] kind_eff;
    logic       eos_hit;
    logic [2:0] pre_new;
    logic [31:0] pos_inc;
    logic [31:0] back_off;

    assign room          = (count_reg <= FIFO_CW'(FIFO_DEPTH - 2));
    assign proceed       = in_valid_reg && room;
    assign s_axis_tready = !in_valid_reg || room;
    assign pop           = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_byte_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
    end

    // byte decode
    assign is_zero    = (in_byte_reg == 8'h00);
    assign is_one     = (in_byte_reg == 8'h01);
    assign sc_hit     = is_one && (zrun_reg >= 2'd2);
    assign kfield     = in_byte_reg[4:0] & KIND_MASK;
    assign kind_byte  = (kfield >= 5'd1 && kfield <= {1'b0, KIND_MAX}) ? kfield[3:0]
                                                                         : KIND_NONE;
    assign first_byte = !kseen_reg;
    assign kind_eff   = first_byte ? kind_byte : ckind_reg;
    assign eos_hit    = first_byte && (kind_byte == KIND_EOS);
    assign pre_new    = (zrun_reg == ZRUN_MAX) ? PREFIX_4 : PREFIX_3;
    assign pos_inc    = pos_reg + 32'd1;
    assign back_off   = {29'd0, pre_new} - 32'd1;

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (in_last_reg)
        begin
            phase_next = PH_EXPECT;
        end
        else
        begin
            unique case (phase_reg)
                PH_EXPECT:
                begin
                    if (is_zero && zrun_reg < ZRUN_MAX)
                        phase_next = PH_EXPECT;
                    else if (sc_hit)
                        phase_next = PH_PAYLOAD;
                    else
                        phase_next = PH_DROP;
                end
                PH_PAYLOAD:
                begin
                    if (eos_hit)
                        phase_next = PH_DROP;
                end
                PH_DROP:
                begin
                    phase_next = PH_DROP;
                end
                default:
                begin
                    phase_next = PH_EXPECT;
                end
            endcase
        end
    end

    // records and data state
    always_comb
    begin
        zrun_next    = zrun_reg;
        pstart_next  = pstart_reg;
        cprefix_next = cprefix_reg;
        ckind_next   = ckind_reg;
        kseen_next   = kseen_reg;
        pos_next     = pos_inc;
        rec0_valid   = 1'b0;
        rec1_valid   = 1'b0;
        rec0         = '{32'd0, 32'd0, PREFIX_NONE, KIND_NONE, STATUS_NO_SC, 1'b1};
        rec1         = '{pos_inc, 32'd0, pre_new, KIND_NONE, STATUS_OK, 1'b1};

        unique case (phase_reg)
            PH_EXPECT:
            begin
                if (is_zero && zrun_reg < ZRUN_MAX)
                begin
                    zrun_next  = zrun_reg + 2'd1;
                    rec0_valid = in_last_reg;
                end
                else if (sc_hit)
                begin
                    cprefix_next = {1'b0, zrun_reg} + 3'd1;
                    pstart_next  = pos_inc;
                    zrun_next    = 2'd0;
                    kseen_next   = 1'b0;
                    ckind_next   = KIND_NONE;
                    rec0_valid   = in_last_reg;
                    rec0         = '{pos_inc, 32'd0, {1'b0, zrun_reg} + 3'd1,
                                     KIND_NONE, STATUS_OK, 1'b1};
                end
                else
                begin
                    rec0_valid = 1'b1;
                end
            end
            PH_PAYLOAD:
            begin
                if (first_byte)
                begin
                    kseen_next = 1'b1;
                    ckind_next = kind_byte;
                end
                if (eos_hit)
                begin
                    rec0_valid = 1'b1;
                    rec0       = '{pstart_reg, 32'd0, cprefix_reg, KIND_EOS, STATUS_EOS, 1'b1};
                end
                else if (sc_hit)
                begin
                    // close the current unit, open the next after this 01
                    rec0_valid   = 1'b1;
                    rec0         = '{pstart_reg, pos_reg - back_off - pstart_reg, cprefix_reg,
                                     kind_eff, STATUS_OK, 1'b0};
                    rec1_valid   = in_last_reg;
                    pstart_next  = pos_inc;
                    cprefix_next = pre_new;
                    ckind_next   = KIND_NONE;
                    kseen_next   = 1'b0;
                    zrun_next    = 2'd0;
                end
                else
                begin
                    if (is_zero)
                        zrun_next = (zrun_reg < ZRUN_MAX) ? zrun_reg + 2'd1 : ZRUN_MAX;
                    else
                        zrun_next = 2'd0;
                    rec0_valid = in_last_reg;
                    rec0       = '{pstart_reg, pos_inc - pstart_reg, cprefix_reg,
                                   kind_eff, STATUS_OK, 1'b1};
                end
            end
            PH_DROP:
            begin
                rec0_valid = 1'b0;
            end
            default:
            begin
                rec0_valid = 1'b0;
            end
        endcase

        if (in_last_reg)
        begin
            zrun_next    = 2'd0;
            pos_next     = 32'd0;
            pstart_next  = 32'd0;
            cprefix_next = PREFIX_NONE;
            ckind_next   = KIND_NONE;
            kseen_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_EXPECT;
            zrun_reg    <= 2'd0;
            pos_reg     <= 32'd0;
            pstart_reg  <= 32'd0;
            cprefix_reg <= PREFIX_NONE;
            ckind_reg   <= KIND_NONE;
            kseen_reg   <= 1'b0;
        end
        else if (proceed)
        begin
            phase_reg   <= phase_next;
            zrun_reg    <= zrun_next;
            pos_reg     <= pos_next;
            pstart_reg  <= pstart_next;
            cprefix_reg <= cprefix_next;
            ckind_reg   <= ckind_next;
            kseen_reg   <= kseen_next;
        end
    end

    // result queue
    logic              push0, push1;
    logic [FIFO_AW-1:0] wr_ptr_p1;

    assign push0     = proceed && rec0_valid;
    assign push1     = proceed && rec0_valid && rec1_valid;
    assign wr_ptr_p1 = wr_ptr_reg + FIFO_AW'(1);

    always_ff @(posedge clk)
    begin
        if (push0)
            fifo_reg[wr_ptr_reg] <= rec0;
        if (push1)
            fifo_reg[wr_ptr_p1] <= rec1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + FIFO_AW'(push0) + FIFO_AW'(push1);
            rd_ptr_reg <= rd_ptr_reg + FIFO_AW'(pop);
            count_reg  <= count_reg + FIFO_CW'(push0) + FIFO_CW'(push1) - FIFO_CW'(pop);
        end
    end

    rec_t head;
    assign head          = fifo_reg[rd_ptr_reg];
    assign m_axis_tvalid = (count_reg != '0);
    assign m_axis_tdata  = {5'd0, head.prefix_bytes, head.payload_len, head.nal_offset};
    assign m_axis_tuser  = {head.status, head.nal_kind};
    assign m_axis_tlast  = head.final_record;

    // checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FIFO_CW'(FIFO_DEPTH))
        else $error("result queue overflow");

    a_err_is_final: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser[5:4] != STATUS_OK) |-> m_axis_tlast)
        else $error("error record not marked final");

    a_last_rewinds: assert property (@(posedge clk) disable iff (!rst_n)
        proceed && in_last_reg |=> (phase_reg == PH_EXPECT) && (pos_reg == 32'd0))
        else $error("scan state not rewound after buffer end");

    a_pair_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        push1 |-> count_reg <= FIFO_CW'(FIFO_DEPTH - 2))
        else $error("two records pushed without room");

endmodule
